// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file socv_checker.sv.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define SOCV_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("socv assertion failed");

// Next-cycle implication, masked during reset
`define SOCV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("socv assertion failed");

`endif

// ===== rtl/socv_pkg.sv =====
// Package for the state-of-charge lookup: widths, OCV table and bracket thresholds.
// No dependencies; used by every module of the block.
package socv_pkg;

	// Table size and derived widths
	localparam int NPTS  = 101;
	localparam int NMID  = NPTS - 1;
	localparam int PCT_W = 7;
	localparam int VH_W  = 18;
	localparam int V_W   = 16;
	localparam int T_W   = 11;

	// Brackets of 1 mV or less never round up
	localparam logic [V_W-1:0] NARROW_BRACKET = 16'd10;

	// Water temperature at and above which no correction applies, 0.1 degC
	localparam logic signed [T_W-1:0] TEMP_REF = 11'sd250;

	// Open-circuit voltage per percent, 0.1 mV
	localparam logic [V_W-1:0] OCV_TAB [NPTS] = '{
		16'd29500, 16'd30200, 16'd30800, 16'd31300, 16'd31750,
		16'd32150, 16'd32500, 16'd32800, 16'd33050, 16'd33300,
		16'd33500, 16'd33700, 16'd33880, 16'd34050, 16'd34200,
		16'd34350, 16'd34500, 16'd34640, 16'd34780, 16'd34900,
		16'd35020, 16'd35140, 16'd35250, 16'd35350, 16'd35450,
		16'd35550, 16'd35640, 16'd35730, 16'd35810, 16'd35890,
		16'd35960, 16'd36030, 16'd36100, 16'd36160, 16'd36220,
		16'd36280, 16'd36340, 16'd36400, 16'd36460, 16'd36520,
		16'd36580, 16'd36640, 16'd36700, 16'd36760, 16'd36820,
		16'd36880, 16'd36940, 16'd37000, 16'd37060, 16'd37130,
		16'd37200, 16'd37270, 16'd37340, 16'd37420, 16'd37500,
		16'd37580, 16'd37670, 16'd37760, 16'd37860, 16'd37960,
		16'd38060, 16'd38170, 16'd38280, 16'd38400, 16'd38520,
		16'd38640, 16'd38770, 16'd38900, 16'd39040, 16'd39180,
		16'd39320, 16'd39460, 16'd39600, 16'd39740, 16'd39880,
		16'd40020, 16'd40160, 16'd40300, 16'd40440, 16'd40580,
		16'd40710, 16'd40820, 16'd40920, 16'd41010, 16'd41100,
		16'd41180, 16'd41260, 16'd41330, 16'd41400, 16'd41470,
		16'd41530, 16'd41590, 16'd41640, 16'd41690, 16'd41740,
		16'd41790, 16'd41840, 16'd41890, 16'd41940, 16'd41970,
		16'd42000
	};

	typedef logic [NMID-1:0] therm_t;

	// Half-unit voltage at which the result steps from i to i+1: the
	// bracket midpoint, or the upper entry when the bracket is narrow.
	function automatic logic [VH_W-1:0] mid_thr(input int unsigned i);
		logic [VH_W-1:0] lo_e;
		logic [VH_W-1:0] hi_e;
		lo_e = VH_W'(OCV_TAB[i]);
		hi_e = VH_W'(OCV_TAB[i + 1]);
		if ((hi_e - lo_e) > VH_W'(NARROW_BRACKET))
			mid_thr = lo_e + hi_e;
		else
			mid_thr = hi_e << 1;
	endfunction

endpackage

// ===== rtl/socv_vcorr.sv =====
// Temperature correction: voltage in half 0.1 mV units, raised below 25 degC.
// Depends on socv_pkg.
module socv_vcorr (
	input  logic [socv_pkg::V_W-1:0]         voltage_code,
	input  logic                             temp_valid,
	input  logic signed [socv_pkg::T_W-1:0]  water_temp,
	output logic [socv_pkg::VH_W-1:0]        vh
);

	logic signed [socv_pkg::T_W:0] diff;
	logic [11:0]                   corr;
	logic                          apply;

	// 1.5 mV per degree is three half units per 0.1 degC
	always_comb begin
		diff  = {socv_pkg::TEMP_REF[socv_pkg::T_W-1], socv_pkg::TEMP_REF}
			- {water_temp[socv_pkg::T_W-1], water_temp};
		apply = temp_valid && (water_temp < socv_pkg::TEMP_REF);
		corr  = 12'(diff[socv_pkg::T_W-1:0]) * 12'd3;
		vh    = {1'b0, voltage_code, 1'b0}
			+ (apply ? socv_pkg::VH_W'(corr) : socv_pkg::VH_W'(0));
	end

endmodule

// ===== rtl/socv_cmp.sv =====
// Compares the corrected voltage with every bracket threshold (thermometer code).
// Depends on socv_pkg.
module socv_cmp (
	input  logic [socv_pkg::VH_W-1:0] vh,
	output socv_pkg::therm_t          therm
);

	// One constant compare per bracket; thresholds rise, so the code is contiguous
	always_comb begin
		for (int unsigned i = 0; i < socv_pkg::NMID; i++) begin
			therm[i] = (vh >= socv_pkg::mid_thr(i));
		end
	end

endmodule

// ===== rtl/socv_enc.sv =====
// Thermometer-to-binary encoder giving the percent result.
// Depends on socv_pkg.
module socv_enc (
	input  socv_pkg::therm_t           therm,
	output logic [socv_pkg::PCT_W-1:0] pct
);

	logic [(2**socv_pkg::PCT_W)-1:0] pad;
	logic [socv_pkg::PCT_W-1:0]      pos;
	logic [socv_pkg::PCT_W-1:0]      cand;

	// Binary search for the count of set bits, one result bit per step
	always_comb begin
		pad = (2**socv_pkg::PCT_W)'(therm);
		pos = '0;
		for (int b = socv_pkg::PCT_W - 1; b >= 0; b--) begin
			cand = pos | (socv_pkg::PCT_W'(1) << b);
			if (pad[cand - socv_pkg::PCT_W'(1)])
				pos = cand;
		end
		pct = pos;
	end

endmodule

// ===== rtl/battery_soc_from_ocv_top.sv =====
// Top level of the OCV state-of-charge lookup: three register stages.
// Depends on socv_pkg, socv_vcorr, socv_cmp and socv_enc.
//
// Takes one battery voltage sample per transaction and returns one state of
// charge in whole percent (0..100), interpolated in a fixed 101-point OCV table
// and rounded half up, with a 1.5 mV/degC boost below 25 degC when the water
// temperature is valid. One transaction is accepted every clock cycle while
// in_stall is low; the stages are the input, threshold-compare and result
// registers. in_stall rises only when all three stages hold data and the
// output is stalled. No configuration, no state between transactions.
module battery_soc_from_ocv_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [socv_pkg::V_W-1:0]        voltage_code,
	input  logic                            temp_valid,
	input  logic signed [socv_pkg::T_W-1:0] water_temp,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [socv_pkg::PCT_W-1:0]      charge_percent
);

	logic                            valid_s1;
	logic [socv_pkg::V_W-1:0]        volt_s1;
	logic                            tv_s1;
	logic signed [socv_pkg::T_W-1:0] temp_s1;
	logic                            valid_s2;
	socv_pkg::therm_t                therm_s2;
	logic                            out_valid_q;
	logic [socv_pkg::PCT_W-1:0]      pct_q;

	logic [socv_pkg::VH_W-1:0]       vh;
	socv_pkg::therm_t                therm;
	logic [socv_pkg::PCT_W-1:0]      pct;
	logic                            en1;
	logic                            en2;
	logic                            en3;

	// Stage enables: a stage loads when it is empty or its contents move on
	assign en3      = !out_valid_q || !out_stall;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	// Datapath
	socv_vcorr u_vcorr (
		.voltage_code (volt_s1),
		.temp_valid   (tv_s1),
		.water_temp   (temp_s1),
		.vh           (vh)
	);

	socv_cmp u_cmp (
		.vh    (vh),
		.therm (therm)
	);

	socv_enc u_enc (
		.therm (therm_s2),
		.pct   (pct)
	);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)
				valid_s1 <= in_valid;
			if (en2)
				valid_s2 <= valid_s1;
			if (en3)
				out_valid_q <= valid_s2;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			volt_s1 <= voltage_code;
			tv_s1   <= temp_valid;
			temp_s1 <= water_temp;
		end
		if (en2 && valid_s1)
			therm_s2 <= therm;
		if (en3 && valid_s2)
			pct_q <= pct;
	end

	assign out_valid      = out_valid_q;
	assign charge_percent = pct_q;

endmodule

// ===== rtl/socv_checker.sv =====
// Port-level checks on the state-of-charge block, bound to the top level.
// Depends on assert_macros.svh and socv_pkg.
`include "assert_macros.svh"

module socv_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [socv_pkg::PCT_W-1:0]      charge_percent
);

	// Result never exceeds the top of the table
	`SOCV_ASSERT_IMPL(a_pct_range, out_valid, charge_percent <= socv_pkg::PCT_W'(socv_pkg::NMID))

	// Input back-pressure only arises from a full, stalled output
	`SOCV_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

	// A stalled result holds
	`SOCV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(charge_percent))

endmodule

bind battery_soc_from_ocv_top socv_checker u_socv_checker (.*);
